// File: rtl/dfp_pkg.sv
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types, constants and helper functions for the decimal fixed-point ALU.
// ----------------------------------------------------------------------------
package dfp_pkg;

	localparam int FRACTION_DIGITS = 8;
	localparam int DATA_W          = 64;
	localparam int DIV_STEPS       = 2;
	localparam int DIV_STAGES      = DATA_W / DIV_STEPS;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_ABS = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_DIVZERO  = 2'd2
	} status_t;

	function automatic logic [DATA_W-1:0] scale_f();
		logic [DATA_W-1:0] s;
		s = DATA_W'(1);
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			s = DATA_W'(s * DATA_W'(10));
		end
		return s;
	endfunction

	localparam logic [DATA_W-1:0] SCALE   = scale_f();
	localparam logic [DATA_W-1:0] SIGN_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// side information that travels along with each item
	typedef struct packed {
		logic              vld;
		logic              wide_op;
		logic              neg;
		status_t           st;
		logic [DATA_W-1:0] res;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
	} dstep_t;

	// one restoring step; remainder stays below the divisor, so it never needs a 65th bit
	function automatic dstep_t div_step(dstep_t cur, logic [DATA_W-1:0] d);
		dstep_t            nxt;
		logic [DATA_W-1:0] sh;
		logic              ge;
		sh = {cur.rem[DATA_W-2:0], cur.quo[DATA_W-1]};
		ge = (sh >= d);
		nxt.rem = ge ? (sh - d) : sh;
		nxt.quo = {cur.quo[DATA_W-2:0], ge};
		return nxt;
	endfunction

	function automatic logic [DATA_W-1:0] mag_f(logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
	endfunction

endpackage

// File: rtl/dfp_mul.sv
// ----------------------------------------------------------------------------
// dfp_mul
// Two-stage 64x64 magnitude multiplier: 32x32 partial products, then the sum.
// ----------------------------------------------------------------------------
module dfp_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dfp_pkg::side_t                side_in,
	input  logic [dfp_pkg::DATA_W-1:0]    x,
	input  logic [dfp_pkg::DATA_W-1:0]    y,
	input  logic [dfp_pkg::DATA_W-1:0]    d_in,
	output dfp_pkg::side_t                side_out,
	output logic [2*dfp_pkg::DATA_W-1:0]  prod,
	output logic [dfp_pkg::DATA_W-1:0]    d_out
);

	localparam int H = dfp_pkg::DATA_W / 2;
	localparam int W = dfp_pkg::DATA_W;

	logic [W-1:0]   p00_s2, p01_s2, p10_s2, p11_s2, d_s2;
	dfp_pkg::side_t side_s2, side_s3;
	logic [2*W-1:0] prod_s3;
	logic [W-1:0]   d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			side_s2 <= side_in;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2  <= W'(x[H-1:0]) * W'(y[H-1:0]);
			p01_s2  <= W'(x[H-1:0]) * W'(y[W-1:H]);
			p10_s2  <= W'(x[W-1:H]) * W'(y[H-1:0]);
			p11_s2  <= W'(x[W-1:H]) * W'(y[W-1:H]);
			d_s2    <= d_in;
			prod_s3 <= (2*W)'(p00_s2) + ((2*W)'(p01_s2) << H) + ((2*W)'(p10_s2) << H)
				+ ((2*W)'(p11_s2) << W);
			d_s3    <= d_s2;
		end
	end

	assign side_out = side_s3;
	assign prod     = prod_s3;
	assign d_out    = d_s3;

endmodule

// File: rtl/dfp_div.sv
// ----------------------------------------------------------------------------
// dfp_div
// Pipelined restoring divider, 128-bit dividend by 64-bit divisor, 64-bit quotient.
// ----------------------------------------------------------------------------
module dfp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dfp_pkg::side_t                side_in,
	input  logic [2*dfp_pkg::DATA_W-1:0]  num,
	input  logic [dfp_pkg::DATA_W-1:0]    den,
	output dfp_pkg::side_t                side_out,
	output logic [dfp_pkg::DATA_W-1:0]    quo,
	output logic                          ovf
);

	localparam int W = dfp_pkg::DATA_W;
	localparam int N = dfp_pkg::DIV_STAGES;

	dfp_pkg::dstep_t step_s [N];
	logic [W-1:0]    d_s    [N];
	logic            ovf_s  [N];
	dfp_pkg::side_t  side_s [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		dfp_pkg::dstep_t src, nxt;
		logic [W-1:0]    src_d;
		logic            src_ovf;
		dfp_pkg::side_t  src_side;

		if (g == 0) begin : g_first
			// quotient fits in 64 bits only when the upper dividend half is below the divisor
			assign src.rem  = num[2*W-1:W];
			assign src.quo  = num[W-1:0];
			assign src_d    = den;
			assign src_ovf  = (num[2*W-1:W] >= den);
			assign src_side = side_in;
		end else begin : g_next
			assign src      = step_s[g-1];
			assign src_d    = d_s[g-1];
			assign src_ovf  = ovf_s[g-1];
			assign src_side = side_s[g-1];
		end

		always_comb begin
			nxt = src;
			for (int k = 0; k < dfp_pkg::DIV_STEPS; k++) begin
				nxt = dfp_pkg::div_step(nxt, src_d);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g] <= '0;
			end else if (en) begin
				side_s[g] <= src_side;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[g] <= nxt;
				d_s[g]    <= src_d;
				ovf_s[g]  <= src_ovf;
			end
		end
	end

	assign side_out = side_s[N-1];
	assign quo      = step_s[N-1].quo;
	assign ovf      = ovf_s[N-1];

endmodule

// File: rtl/decimal_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu
// Signed 64-bit decimal fixed-point ALU, values scaled by ten to the eighth.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry command, operand_a and operand_b.
// Output channel: out_valid / out_stall carry result and status
// (0 ok, 1 overflow, 2 division by zero; result is zero on any error).
// Every command, simple or not, goes down the same pipe, so results leave
// in order. The pipe is made of one decode stage, two multiplier
// stages, 32 divider stages of two restoring steps each, and the output
// register. Multiply divides the product by the scale and divide
// multiplies the dividend by it, both in the same divider.
// Throughput is one item per cycle while out_stall does not hold the pipe.
// While out_valid is high and out_stall is set, the whole pipe holds and
// in_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits; the pipe is ready in the first cycle after.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic signed [63:0] operand_a,
	input  logic signed [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [63:0] result,
	output logic [1:0]  status
);

	localparam int W = dfp_pkg::DATA_W;

	logic           en;
	dfp_pkg::side_t side_c, side_s1, side_mul, side_div;
	logic [W-1:0]   ma, mb, ma_s1, mb_s1, mul_y, mul_d;
	logic [W-1:0]   sum, dif, quo, mul_d_out;
	logic [2*W-1:0] prod;
	logic           div_ovf;
	logic           cmd_div_s1;
	logic           cmd_div;
	logic           out_vld_q;
	logic [W-1:0]   res_q;
	dfp_pkg::status_t st_q;
	dfp_pkg::status_t fin_st;
	logic [W-1:0]   fin_res;

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	// stage 1 decode and simple operations
	always_comb begin
		ma      = dfp_pkg::mag_f(operand_a);
		mb      = dfp_pkg::mag_f(operand_b);
		sum     = operand_a + operand_b;
		dif     = operand_a - operand_b;
		cmd_div = 1'b0;
		side_c  = '0;
		side_c.vld = in_valid;
		side_c.neg = operand_a[W-1] ^ operand_b[W-1];
		side_c.st  = dfp_pkg::ST_OK;
		case (dfp_pkg::cmd_t'(command))
			dfp_pkg::CMD_ADD: begin
				if (operand_a[W-1] == operand_b[W-1] && sum[W-1] != operand_a[W-1])
					side_c.st = dfp_pkg::ST_OVERFLOW;
				else
					side_c.res = sum;
			end
			dfp_pkg::CMD_SUB: begin
				if (operand_a[W-1] != operand_b[W-1] && dif[W-1] != operand_a[W-1])
					side_c.st = dfp_pkg::ST_OVERFLOW;
				else
					side_c.res = dif;
			end
			dfp_pkg::CMD_MUL: begin
				side_c.wide_op = 1'b1;
			end
			dfp_pkg::CMD_DIV: begin
				side_c.wide_op = 1'b1;
				cmd_div        = 1'b1;
				if (operand_b == '0)
					side_c.st = dfp_pkg::ST_DIVZERO;
			end
			dfp_pkg::CMD_NEG: begin
				if (operand_a == dfp_pkg::SIGN_MIN)
					side_c.st = dfp_pkg::ST_OVERFLOW;
				else
					side_c.res = W'(0) - operand_a;
			end
			dfp_pkg::CMD_ABS: begin
				if (operand_a == dfp_pkg::SIGN_MIN)
					side_c.st = dfp_pkg::ST_OVERFLOW;
				else
					side_c.res = ma;
			end
			default: begin
				side_c.res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1      <= ma;
			mb_s1      <= mb;
			cmd_div_s1 <= cmd_div;
		end
	end

	// divide scales the dividend, multiply scales down through the divisor
	assign mul_y = cmd_div_s1 ? dfp_pkg::SCALE : mb_s1;
	assign mul_d = cmd_div_s1 ? mb_s1 : dfp_pkg::SCALE;

	dfp_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_s1),
		.x        (ma_s1),
		.y        (mul_y),
		.d_in     (mul_d),
		.side_out (side_mul),
		.prod     (prod),
		.d_out    (mul_d_out)
	);

	dfp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.side_in  (side_mul),
		.num      (prod),
		.den      (mul_d_out),
		.side_out (side_div),
		.quo      (quo),
		.ovf      (div_ovf)
	);

	// sign and range check of the quotient
	always_comb begin
		fin_st  = side_div.st;
		fin_res = side_div.res;
		if (side_div.wide_op && side_div.st == dfp_pkg::ST_OK) begin
			if (div_ovf || (side_div.neg ? (quo > dfp_pkg::SIGN_MIN) : quo[W-1]))
				fin_st = dfp_pkg::ST_OVERFLOW;
			else
				fin_res = side_div.neg ? (W'(0) - quo) : quo;
		end
		if (fin_st != dfp_pkg::ST_OK)
			fin_res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_div.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin_res;
			st_q  <= fin_st;
		end
	end

	assign out_valid = out_vld_q;
	assign result    = res_q;
	assign status    = st_q;

endmodule

// File: rtl/dfp_checker.sv
// ----------------------------------------------------------------------------
// dfp_checker
// Port-level assertions for the decimal fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module dfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result,
	input logic [1:0]  status
);

	// held output transfer keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
		else $error("output changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> result == 64'd0)
		else $error("nonzero result on error");

	// input side only backs up when the output side is blocked
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

endmodule

bind decimal_fixed_point_alu dfp_checker u_dfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result),
	.status    (status)
);
